[sv/ntfs_run_list_decoder_macros.svh]
// ----------------------------------------------------------------------------
// ntfs run list decoder assertion macros
// shared concurrent assertion forms, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef NTFS_RUN_LIST_DECODER_MACROS_SVH
`define NTFS_RUN_LIST_DECODER_MACROS_SVH

// same-cycle implication
`define NTFSRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NTFSRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ntfsrl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfsrl_pkg
// shared types and constants of the ntfs run list decoder
// ----------------------------------------------------------------------------
package ntfsrl_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned WordW = 64;

    // largest byte count a header nibble may give
    localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             list_start;
    } t_in_beat;

    typedef struct packed {
        logic [WordW-1:0]        run_length;
        logic signed [WordW-1:0] run_start;
        logic                    list_end;
        logic                    bad_header;
    } t_result;

endpackage

[sv/ntfsrl_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfsrl_in_if
// run list byte channel: one list byte per beat
// ----------------------------------------------------------------------------
interface ntfsrl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       list_start;

    modport source (output valid, output data_byte, output list_start, input ready);
    modport sink   (input valid, input data_byte, input list_start, output ready);
endinterface

[sv/ntfsrl_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfsrl_out_if
// decoded run channel: one run, end marker or bad header flag per beat
// ----------------------------------------------------------------------------
interface ntfsrl_out_if;
    logic               valid;
    logic               ready;
    logic [63:0]        run_length;
    logic signed [63:0] run_start;
    logic               list_end;
    logic               bad_header;

    modport source (output valid, output run_length, output run_start,
                    output list_end, output bad_header, input ready);
    modport sink   (input valid, input run_length, input run_start,
                    input list_end, input bad_header, output ready);
endinterface

[sv/ntfsrl_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfsrl_core
// run list state machine: header decode, field collection, start update
// ----------------------------------------------------------------------------
`include "ntfs_run_list_decoder_macros.svh"

module ntfsrl_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_strobe,
    input  ntfsrl_pkg::t_in_beat i_beat,
    output logic                 o_res_valid,
    output ntfsrl_pkg::t_result  o_res
);
    import ntfsrl_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_OFFSET = 2'd2;

    logic [1:0]       r_phase, n_phase;
    logic [3:0]       r_left, n_left;
    logic [3:0]       r_off_total, n_off_total;
    logic [2:0]       r_pos, n_pos;
    logic [WordW-1:0] r_len_acc, n_len_acc;
    logic [WordW-1:0] r_delta, n_delta;
    logic [WordW-1:0] r_prev, n_prev;

    logic [1:0]       eff_phase;
    logic [WordW-1:0] prev_base;
    logic [WordW-1:0] byte_shifted;
    logic [WordW-1:0] len_or;
    logic [WordW-1:0] delta_or;
    logic [WordW-1:0] delta_fill;
    logic [WordW-1:0] start_sum;
    logic [WordW-1:0] add_delta;
    logic [3:0]       left_dec;
    logic [3:0]       pos_inc;
    logic [3:0]       nlen, noff;
    logic             hdr_bad;
    logic             off_last;

    always_comb begin
        // list_start forces a header read; the unused phase code reads as header
        if (i_beat.list_start || (r_phase != PH_LENGTH && r_phase != PH_OFFSET)) begin
            eff_phase = PH_HEADER;
        end else begin
            eff_phase = r_phase;
        end
        prev_base    = i_beat.list_start ? '0 : r_prev;
        byte_shifted = {{(WordW-ByteW){1'b0}}, i_beat.data_byte} << {r_pos, 3'b000};
        len_or       = r_len_acc | byte_shifted;
        delta_or     = r_delta | byte_shifted;
        // sign fill above the offset field; a full eight byte field shifts it away
        delta_fill   = i_beat.data_byte[ByteW-1]
                     ? delta_or | ({WordW{1'b1}} << {r_off_total, 3'b000}) : delta_or;
        left_dec     = r_left - 4'd1;
        pos_inc      = {1'b0, r_pos} + 4'd1;
        off_last     = pos_inc >= r_off_total;
        nlen         = i_beat.data_byte[3:0];
        noff         = i_beat.data_byte[7:4];
        hdr_bad      = (nlen > MAX_FIELD_BYTES) || (noff > MAX_FIELD_BYTES);
        add_delta    = (eff_phase == PH_OFFSET) ? delta_fill : r_delta;
        start_sum    = r_prev + add_delta;
    end

    always_comb begin
        n_phase     = r_phase;
        n_left      = r_left;
        n_off_total = r_off_total;
        n_pos       = r_pos;
        n_len_acc   = r_len_acc;
        n_delta     = r_delta;
        n_prev      = r_prev;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_strobe) begin
            case (eff_phase)
                PH_LENGTH: begin
                    n_len_acc = len_or;
                    n_pos     = r_pos + 3'd1;
                    n_left    = left_dec;
                    if (left_dec == 4'd0) begin
                        n_pos = '0;
                        if (r_off_total != 4'd0) begin
                            n_phase = PH_OFFSET;
                        end else begin
                            n_phase          = PH_HEADER;
                            n_prev           = start_sum;
                            o_res_valid      = 1'b1;
                            o_res.run_length = len_or;
                            o_res.run_start  = start_sum;
                        end
                    end
                end
                PH_OFFSET: begin
                    if (off_last) begin
                        n_delta          = delta_fill;
                        n_phase          = PH_HEADER;
                        n_pos            = '0;
                        n_prev           = start_sum;
                        o_res_valid      = 1'b1;
                        o_res.run_length = r_len_acc;
                        o_res.run_start  = start_sum;
                    end else begin
                        n_delta = delta_or;
                        n_pos   = pos_inc[2:0];
                    end
                end
                default: begin
                    n_prev    = prev_base;
                    n_phase   = PH_HEADER;
                    n_pos     = '0;
                    n_len_acc = '0;
                    n_delta   = '0;
                    if (i_beat.data_byte == '0) begin
                        o_res_valid    = 1'b1;
                        o_res.list_end = 1'b1;
                    end else if (hdr_bad) begin
                        o_res_valid      = 1'b1;
                        o_res.bad_header = 1'b1;
                    end else begin
                        n_left      = nlen;
                        n_off_total = noff;
                        n_phase     = (nlen != 4'd0) ? PH_LENGTH : PH_OFFSET;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_left      <= '0;
            r_off_total <= '0;
            r_pos       <= '0;
            r_len_acc   <= '0;
            r_delta     <= '0;
            r_prev      <= '0;
        end else begin
            r_phase     <= n_phase;
            r_left      <= n_left;
            r_off_total <= n_off_total;
            r_pos       <= n_pos;
            r_len_acc   <= n_len_acc;
            r_delta     <= n_delta;
            r_prev      <= n_prev;
        end
    end

    `NTFSRL_ASSERT_NOW(a_flags_exclusive, i_clk, i_rst_n, o_res_valid,
        !(o_res.list_end && o_res.bad_header), "end marker and bad header together")
    `NTFSRL_ASSERT_NEXT(a_good_header_enters_field, i_clk, i_rst_n,
        i_strobe && eff_phase == PH_HEADER && i_beat.data_byte != '0 && !hdr_bad,
        r_phase == PH_LENGTH || r_phase == PH_OFFSET, "valid header did not open a field")
    `NTFSRL_ASSERT_NEXT(a_run_updates_start, i_clk, i_rst_n,
        o_res_valid && !o_res.list_end && !o_res.bad_header,
        r_prev == $past(o_res.run_start) && r_phase == PH_HEADER,
        "finished run did not update running start")

endmodule

[sv/ntfs_run_list_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfs_run_list_decoder
// decodes an ntfs data run list byte stream into runs of length and start
// ----------------------------------------------------------------------------
// Takes one run list byte per cycle while the output is not stalled, with no
// gaps needed between runs or lists. A beat is registered in the input
// register, decoded once the output register is free, and its result, if any,
// lands in the output register. The rate is set by the decoder's state loop,
// whose longest path is the 64-bit add of the signed offset to the running
// start. A zero header gives an end marker; a header nibble above eight gives
// a bad header beat and the header is dropped. The output register and the
// input register decouple the two sides, so a stalled result still lets one
// more byte be taken.
module ntfs_run_list_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ntfsrl_in_if.sink     i_run_in,
    ntfsrl_out_if.source  o_run_out
);
    import ntfsrl_pkg::*;

    logic     r_in_valid;
    t_in_beat r_in_beat;
    logic     r_out_valid;
    t_result  r_out;

    logic     out_free;
    logic     consume;
    logic     res_valid;
    t_result  res;

    assign out_free       = !r_out_valid || o_run_out.ready;
    assign consume        = r_in_valid && out_free;
    assign i_run_in.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_run_in.ready) begin
            r_in_valid <= i_run_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run_in.ready && i_run_in.valid) begin
            r_in_beat.data_byte  <= i_run_in.data_byte;
            r_in_beat.list_start <= i_run_in.list_start;
        end
    end

    ntfsrl_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_strobe    (consume),
        .i_beat      (r_in_beat),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= consume && res_valid;
        end
    end

    // result payload only moves when a new beat is produced
    always_ff @(posedge i_clk) begin
        if (consume && res_valid) begin
            r_out <= res;
        end
    end

    assign o_run_out.valid      = r_out_valid;
    assign o_run_out.run_length = r_out.run_length;
    assign o_run_out.run_start  = r_out.run_start;
    assign o_run_out.list_end   = r_out.list_end;
    assign o_run_out.bad_header = r_out.bad_header;

endmodule
